[rtl/tghd_pkg.sv]
`timescale 1ns / 1ps

package tghd_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COORD_W = 10;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IN_W    = 56;
    localparam int unsigned OUT_W   = 32;

    localparam logic [MS_W-1:0]    BACK_HOLD_RST  = 16'd700;
    localparam logic [MS_W-1:0]    SHOT_HOLD_RST  = 16'd1100;
    localparam logic [COORD_W-1:0] TAP_MOVE_RST   = 10'd10;
    localparam logic [MS_W-1:0]    TAP_MAX_RST    = 16'd350;
    localparam logic [COORD_W-1:0] SWIPE_MIN_RST  = 10'd60;
    localparam logic [MS_W-1:0]    SWIPE_MAX_RST  = 16'd900;
    localparam logic [COORD_W-1:0] NAV_TOP_RST    = 10'd220;
    localparam logic [COORD_W-1:0] NAV_ZONE_RST   = 10'd107;

    typedef enum logic [2:0] {
        REG_BACK_HOLD  = 3'd0,
        REG_SHOT_HOLD  = 3'd1,
        REG_TAP_MOVE   = 3'd2,
        REG_TAP_MAX    = 3'd3,
        REG_SWIPE_MIN  = 3'd4,
        REG_SWIPE_MAX  = 3'd5,
        REG_NAV_TOP    = 3'd6,
        REG_NAV_ZONE   = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        SWIPE_NONE  = 3'd0,
        SWIPE_LEFT  = 3'd1,
        SWIPE_RIGHT = 3'd2,
        SWIPE_UP    = 3'd3,
        SWIPE_DOWN  = 3'd4
    } swipe_t;

    // touch classifier thresholds
    typedef struct packed {
        logic [COORD_W-1:0] tap_move_px;
        logic [MS_W-1:0]    tap_max_ms;
        logic [COORD_W-1:0] swipe_min_px;
        logic [MS_W-1:0]    swipe_max_ms;
        logic [COORD_W-1:0] nav_bar_top;
        logic [COORD_W-1:0] nav_zone_width;
    } touch_cfg_t;

    typedef struct packed {
        logic               nav_up;
        logic               nav_down;
        logic               narrator_tap;
        logic               tap_seen;
        logic [COORD_W-1:0] tap_x;
        logic [COORD_W-1:0] tap_y;
        swipe_t             swipe;
    } touch_ev_t;

endpackage

[rtl/touch_gesture_and_hold_detector.sv]
`timescale 1ns / 1ps

// Touch gesture and button hold detector.
// One frame sample enters per s_tvalid/s_tready beat; exactly one result beat
// leaves on m_* for every input beat, in order.
// s_tdata carries now_ms, both button levels, touch press/release edges and
// the touch coordinates; m_tdata carries nav zone taps, hold events, the tap
// position, the swipe code and an any-event flag.
// Thresholds are written on cfg_we/cfg_addr/cfg_wdata, one register per
// write, taking effect at once; write them only while no beats are in flight.
// A sample in the input register is classified combinationally and its result
// is loaded into the output register, which drives m_tvalid. Throughput: one
// beat per cycle while the output is not stalled by m_tready, set by the
// combinational classify stage between the two registers.
// When m_tready is low the output register holds its beat, the input register
// holds one more sample, and s_tready drops once both are full.
// Reset clears the pipeline valids, all hold and touch tracking state, and
// loads the default thresholds.
module touch_gesture_and_hold_detector
(
    input  logic                        clk,
    input  logic                        rst_n,
    // now_ms[31:0], back_button_down, shot_button_down, touch_pressed,
    // touch_released, touch_x[9:0], touch_y[9:0]
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tghd_pkg::IN_W-1:0]   s_tdata,
    // nav_up, nav_down, narrator_tap, back_hold, screenshot_hold, tap_seen,
    // tap_x[9:0], tap_y[9:0], swipe[2:0], any_event, 2 zero bits
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tghd_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_addr,
    input  logic [tghd_pkg::CFG_W-1:0]  cfg_wdata
);
    import tghd_pkg::*;

    logic              in_valid_reg;
    logic [IN_W-1:0]   in_data_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;
    logic              advance, step;

    logic [MS_W-1:0]   back_hold_ms_reg;
    logic [MS_W-1:0]   shot_hold_ms_reg;
    touch_cfg_t        tcfg_reg;

    logic [TIME_W-1:0]  now_ms;
    logic               back_down, shot_down, pressed, released;
    logic [COORD_W-1:0] tx, ty;
    logic               back_ev, shot_ev, any_ev;
    touch_ev_t          tev;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign now_ms    = in_data_reg[31:0];
    assign back_down = in_data_reg[32];
    assign shot_down = in_data_reg[33];
    assign pressed   = in_data_reg[34];
    assign released  = in_data_reg[35];
    assign tx        = in_data_reg[45:36];
    assign ty        = in_data_reg[55:46];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_hold_ms_reg     <= BACK_HOLD_RST;
            shot_hold_ms_reg     <= SHOT_HOLD_RST;
            tcfg_reg.tap_move_px    <= TAP_MOVE_RST;
            tcfg_reg.tap_max_ms     <= TAP_MAX_RST;
            tcfg_reg.swipe_min_px   <= SWIPE_MIN_RST;
            tcfg_reg.swipe_max_ms   <= SWIPE_MAX_RST;
            tcfg_reg.nav_bar_top    <= NAV_TOP_RST;
            tcfg_reg.nav_zone_width <= NAV_ZONE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_BACK_HOLD: back_hold_ms_reg        <= cfg_wdata;
                REG_SHOT_HOLD: shot_hold_ms_reg        <= cfg_wdata;
                REG_TAP_MOVE:  tcfg_reg.tap_move_px    <= cfg_wdata[COORD_W-1:0];
                REG_TAP_MAX:   tcfg_reg.tap_max_ms     <= cfg_wdata;
                REG_SWIPE_MIN: tcfg_reg.swipe_min_px   <= cfg_wdata[COORD_W-1:0];
                REG_SWIPE_MAX: tcfg_reg.swipe_max_ms   <= cfg_wdata;
                REG_NAV_TOP:   tcfg_reg.nav_bar_top    <= cfg_wdata[COORD_W-1:0];
                REG_NAV_ZONE:  tcfg_reg.nav_zone_width <= cfg_wdata[COORD_W-1:0];
                default:       ;
            endcase
        end
    end

    tghd_hold u_back_hold
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .down     (back_down),
        .now_ms   (now_ms),
        .limit_ms (back_hold_ms_reg),
        .fire     (back_ev)
    );

    tghd_hold u_shot_hold
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .down     (shot_down),
        .now_ms   (now_ms),
        .limit_ms (shot_hold_ms_reg),
        .fire     (shot_ev)
    );

    tghd_touch u_touch
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .cfg            (tcfg_reg),
        .now_ms         (now_ms),
        .touch_pressed  (pressed),
        .touch_released (released),
        .touch_x        (tx),
        .touch_y        (ty),
        .ev             (tev)
    );

    always_comb
    begin
        any_ev = tev.nav_up | tev.nav_down | tev.narrator_tap | back_ev | shot_ev
                 | tev.tap_seen | (tev.swipe != SWIPE_NONE);
        out_data_next = {2'b00, any_ev, tev.swipe, tev.tap_y, tev.tap_x, tev.tap_seen,
                         shot_ev, back_ev, tev.narrator_tap, tev.nav_down, tev.nav_up};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata;
        if (step)
            out_data_reg <= out_data_next;
    end

endmodule

[rtl/tghd_hold.sv]
`timescale 1ns / 1ps

module tghd_hold
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        down,
    input  logic [tghd_pkg::TIME_W-1:0] now_ms,
    input  logic [tghd_pkg::MS_W-1:0]   limit_ms,
    output logic                        fire
);
    import tghd_pkg::*;

    logic              started_reg, started_next;
    logic              fired_reg, fired_next;
    logic [TIME_W-1:0] t0_reg, t0_next;
    logic [TIME_W-1:0] dt;

    always_comb
    begin
        fire         = 1'b0;
        started_next = 1'b0;
        fired_next   = 1'b0;
        t0_next      = '0;
        dt           = '0;
        if (down)
        begin
            started_next = 1'b1;
            t0_next      = started_reg ? t0_reg : now_ms;
            // wraps modulo 2^32
            dt           = now_ms - t0_next;
            fire         = !fired_reg && (dt >= {{(TIME_W-MS_W){1'b0}}, limit_ms});
            fired_next   = fired_reg | fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            fired_reg   <= 1'b0;
            t0_reg      <= '0;
        end
        else if (step)
        begin
            started_reg <= started_next;
            fired_reg   <= fired_next;
            t0_reg      <= t0_next;
        end
    end

endmodule

[rtl/tghd_touch.sv]
`timescale 1ns / 1ps

module tghd_touch
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  tghd_pkg::touch_cfg_t         cfg,
    input  logic [tghd_pkg::TIME_W-1:0]  now_ms,
    input  logic                         touch_pressed,
    input  logic                         touch_released,
    input  logic [tghd_pkg::COORD_W-1:0] touch_x,
    input  logic [tghd_pkg::COORD_W-1:0] touch_y,
    output tghd_pkg::touch_ev_t          ev
);
    import tghd_pkg::*;

    logic               active_reg, active_next;
    logic [COORD_W-1:0] sx_reg, sx_next;
    logic [COORD_W-1:0] sy_reg, sy_next;
    logic [TIME_W-1:0]  st_reg, st_next;

    logic [TIME_W-1:0]  dt;
    logic [COORD_W-1:0] adx, ady;
    logic               x_neg, y_neg;
    logic [COORD_W:0]   adx2, ady2, zone2;
    logic               is_tap, is_hswipe, is_vswipe;

    always_comb
    begin
        // press is handled before release in the same beat
        active_next = active_reg | touch_pressed;
        sx_next     = touch_pressed ? touch_x : sx_reg;
        sy_next     = touch_pressed ? touch_y : sy_reg;
        st_next     = touch_pressed ? now_ms  : st_reg;

        dt    = now_ms - st_next;
        x_neg = touch_x < sx_next;
        y_neg = touch_y < sy_next;
        adx   = x_neg ? (sx_next - touch_x) : (touch_x - sx_next);
        ady   = y_neg ? (sy_next - touch_y) : (touch_y - sy_next);
        adx2  = {adx, 1'b0};
        ady2  = {ady, 1'b0};
        zone2 = {cfg.nav_zone_width, 1'b0};

        is_tap    = (dt <= {{(TIME_W-MS_W){1'b0}}, cfg.tap_max_ms})
                    && (adx <= cfg.tap_move_px) && (ady <= cfg.tap_move_px);
        is_hswipe = (dt <= {{(TIME_W-MS_W){1'b0}}, cfg.swipe_max_ms})
                    && (adx >= cfg.swipe_min_px) && ({1'b0, adx} > ady2);
        is_vswipe = (dt <= {{(TIME_W-MS_W){1'b0}}, cfg.swipe_max_ms})
                    && (ady >= cfg.swipe_min_px) && ({1'b0, ady} > adx2);

        ev = '0;
        ev.swipe = SWIPE_NONE;
        if (active_next && touch_released)
        begin
            active_next = 1'b0;
            if (is_tap)
            begin
                if (touch_y >= cfg.nav_bar_top)
                begin
                    if (touch_x < cfg.nav_zone_width)
                        ev.nav_up = 1'b1;
                    else if ({1'b0, touch_x} >= zone2)
                        ev.nav_down = 1'b1;
                    else
                        ev.narrator_tap = 1'b1;
                end
                else
                begin
                    ev.tap_seen = 1'b1;
                    ev.tap_x    = touch_x;
                    ev.tap_y    = touch_y;
                end
            end
            else if (is_hswipe)
                ev.swipe = x_neg ? SWIPE_LEFT : SWIPE_RIGHT;
            else if (is_vswipe)
                ev.swipe = y_neg ? SWIPE_UP : SWIPE_DOWN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            st_reg     <= '0;
        end
        else if (step)
        begin
            active_reg <= active_next;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
            st_reg     <= st_next;
        end
    end

endmodule
